@@ design/unsigned_64bit_divider_core_assert.svh @@
// Assertion macros for the divider core.
`ifndef UNSIGNED_64BIT_DIVIDER_CORE_ASSERT_SVH
`define UNSIGNED_64BIT_DIVIDER_CORE_ASSERT_SVH

`ifndef SYNTHESIS

`define UDIV_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

`define UDIV_ASSERT_DELAY(label, clk, rst_n, ante, dly, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> ##(dly) (cons)) \
		else $error(msg);

`else

`define UDIV_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)

`define UDIV_ASSERT_DELAY(label, clk, rst_n, ante, dly, cons, msg)

`endif

`endif

@@ design/udiv64_pkg.sv @@
package udiv64_pkg;

	localparam int unsigned DATA_WIDTH_DEF = 64;

	typedef struct packed {
		logic valid;
		logic dbz;
	} ctrl_t;

endpackage

@@ design/udiv64_step.sv @@
module udiv64_step
	import udiv64_pkg::*;
#(
	parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  logic [DATA_WIDTH-1:0] part,
	input  logic [DATA_WIDTH-1:0] dq,
	input  logic [DATA_WIDTH-1:0] divisor,
	output logic [DATA_WIDTH-1:0] part_next,
	output logic [DATA_WIDTH-1:0] dq_next
);

	logic                  carry;
	logic [DATA_WIDTH-1:0] shifted;
	logic [DATA_WIDTH:0]   diff;
	logic                  take;

	// Shift the next dividend bit in; the bit shifted out acts as a carry.
	assign carry   = part[DATA_WIDTH-1];
	assign shifted = {part[DATA_WIDTH-2:0], dq[DATA_WIDTH-1]};
	assign diff    = {carry, shifted} - {1'b0, divisor};
	// No borrow means the widened remainder is not less than the divisor.
	assign take    = ~diff[DATA_WIDTH];

	always_comb begin
		part_next = take ? diff[DATA_WIDTH-1:0] : shifted;
		dq_next   = {dq[DATA_WIDTH-2:0], take};
	end

endmodule

@@ design/unsigned_64bit_divider_core.sv @@
// Unsigned restoring divider, DATA_WIDTH bits (default 64).
// Input: drive dividend and divisor with start high; the transaction is
// taken at the rising edge where start is high and busy is low. busy stays
// low, so a new pair may be issued in every cycle.
// Output: quotient, remainder and divide_by_zero appear together with done
// for exactly one cycle, once the transaction has passed all DATA_WIDTH
// pipeline stages. Results leave in issue order.
// Throughput is one division per cycle; the datapath is a chain of
// DATA_WIDTH pipeline stages, each holding one compare-and-subtract step.
// A zero divisor sets divide_by_zero, gives an all-ones quotient and
// returns the dividend as the remainder.
// Reset (arst_n low) clears the stage valid bits at once, dropping every
// division in flight; no result is delivered for them.
// The receiver cannot stall: each result must be taken in its done cycle.
`include "unsigned_64bit_divider_core_assert.svh"

module unsigned_64bit_divider_core
	import udiv64_pkg::*;
#(
	parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic [DATA_WIDTH-1:0] dividend,
	input  logic [DATA_WIDTH-1:0] divisor,
	output logic                  done,
	output logic [DATA_WIDTH-1:0] quotient,
	output logic [DATA_WIDTH-1:0] remainder,
	output logic                  divide_by_zero
);

	ctrl_t                 ctrl_s [1:DATA_WIDTH];
	logic [DATA_WIDTH-1:0] part_s [1:DATA_WIDTH];
	logic [DATA_WIDTH-1:0] dq_s   [1:DATA_WIDTH];
	logic [DATA_WIDTH-1:0] dvs_s  [1:DATA_WIDTH];

	ctrl_t ctrl_in;

	assign busy = 1'b0;

	always_comb begin
		ctrl_in.valid = start;
		ctrl_in.dbz   = (divisor == '0);
	end

	for (genvar i = 1; i <= DATA_WIDTH; i++) begin : g_stage
		ctrl_t                 ctrl_prev;
		logic [DATA_WIDTH-1:0] part_prev;
		logic [DATA_WIDTH-1:0] dq_prev;
		logic [DATA_WIDTH-1:0] dvs_prev;
		logic [DATA_WIDTH-1:0] part_next;
		logic [DATA_WIDTH-1:0] dq_next;

		if (i == 1) begin : g_first
			// Start with an empty remainder and the dividend in the shift word.
			assign ctrl_prev = ctrl_in;
			assign part_prev = '0;
			assign dq_prev   = dividend;
			assign dvs_prev  = divisor;
		end else begin : g_rest
			assign ctrl_prev = ctrl_s[i-1];
			assign part_prev = part_s[i-1];
			assign dq_prev   = dq_s[i-1];
			assign dvs_prev  = dvs_s[i-1];
		end

		udiv64_step #(
			.DATA_WIDTH(DATA_WIDTH)
		) u_step (
			.part     (part_prev),
			.dq       (dq_prev),
			.divisor  (dvs_prev),
			.part_next(part_next),
			.dq_next  (dq_next)
		);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctrl_s[i] <= '0;
			end else begin
				ctrl_s[i] <= ctrl_prev;
			end
		end

		// Advance payload only behind a valid transaction.
		always_ff @(posedge clk) begin
			if (ctrl_prev.valid) begin
				part_s[i] <= part_next;
				dq_s[i]   <= dq_next;
				dvs_s[i]  <= dvs_prev;
			end
		end
	end

	always_comb begin
		done           = ctrl_s[DATA_WIDTH].valid;
		divide_by_zero = ctrl_s[DATA_WIDTH].dbz;
		quotient       = dq_s[DATA_WIDTH];
		remainder      = part_s[DATA_WIDTH];
	end

	`UDIV_ASSERT_DELAY(a_latency, clk, arst_n, start, DATA_WIDTH, done, "result missing after pipeline latency")
	`UDIV_ASSERT_IMPLY(a_dbz_quot, clk, arst_n, done && divide_by_zero, quotient == '1, "zero divisor quotient not all ones")
	`UDIV_ASSERT_IMPLY(a_rem_range, clk, arst_n, done && !divide_by_zero, remainder < dvs_s[DATA_WIDTH], "remainder not below divisor")

endmodule
